>>> rtl/olar_pkg.sv
`default_nettype none
package olar_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

endpackage
`default_nettype wire

>>> rtl/olar_ram.sv
`default_nettype none
module olar_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> rtl/ordered_list_append_remove.sv
// Append: result the cycle after the word is accepted; busy stays low.
// Remove: each entry searched takes a read state and a compare state, then each entry
//   shifted down takes a read state and a write state; busy meanwhile, result the cycle after.
// Read out: each emitted entry takes an address phase and an emit phase; results cannot be stalled.
// These steps are paced by the registered read of the single entry RAM.
// Synchronous active-low reset empties the list.
`default_nettype none
module ordered_list_append_remove (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic signed [olar_pkg::DATA_W-1:0] i_item_value,
    output logic                                o_strobe,
    output logic [1:0]                          o_status,
    output logic signed [olar_pkg::DATA_W-1:0]  o_entry_value,
    output logic                                o_last
);
    import olar_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SRCH_RD = 6'b000010,
        S_SRCH_CM = 6'b000100,
        S_SH_RD   = 6'b001000,
        S_SH_WR   = 6'b010000,
        S_OUT     = 6'b100000
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic [DATA_W-1:0]        r_key, n_key;
    logic                     r_strobe, n_strobe;
    logic [1:0]               r_status, n_status;
    logic [DATA_W-1:0]        r_value, n_value;
    logic                     r_last, n_last;
    logic                     r_phase;

    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic [DATA_W-1:0]        wdata;
    logic [DATA_W-1:0]        rdata;
    logic [CNT_W-1:0]         idx_inc;
    logic                     at_tail;

    olar_ram #(.DEPTH(CAPACITY), .WIDTH(DATA_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    assign idx_inc = r_idx + CNT_W'(1);
    assign at_tail = (idx_inc == r_count);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_key    = r_key;
        n_strobe = 1'b0;
        n_status = ST_DONE;
        n_value  = '0;
        n_last   = 1'b1;
        we       = 1'b0;
        waddr    = r_count[ADDR_W-1:0];
        wdata    = i_item_value;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key = i_item_value;
                    n_idx = '0;
                    case (i_req_type)
                        REQ_APPEND: begin
                            n_strobe = 1'b1;
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        REQ_REMOVE: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_state = S_SRCH_RD;
                            end
                        end
                        REQ_READ: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_OUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SRCH_RD: n_state = S_SRCH_CM;
            S_SRCH_CM: begin
                if (rdata == r_key) begin
                    if (at_tail) begin
                        n_count  = r_count - CNT_W'(1);
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = S_SH_RD;
                    end
                end else if (at_tail) begin
                    n_strobe = 1'b1;
                    n_status = ST_NOT_FOUND;
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_SRCH_RD;
                end
            end
            S_SH_RD: n_state = S_SH_WR;
            S_SH_WR: begin
                we    = 1'b1;
                waddr = r_idx[ADDR_W-1:0] - ADDR_W'(1);
                wdata = rdata;
                if (at_tail) begin
                    n_count  = r_count - CNT_W'(1);
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_SH_RD;
                end
            end
            S_OUT: begin
                // even phase addresses the entry, odd phase emits it
                if (r_phase) begin
                    n_strobe = 1'b1;
                    n_value  = rdata;
                    n_last   = at_tail;
                    if (at_tail) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = idx_inc;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_phase  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            r_phase  <= (r_state == S_OUT) ? !r_phase : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_status <= n_status;
        r_value  <= n_value;
        r_last   <= n_last;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_entry_value = r_value;
    assign o_last        = r_last;

endmodule
`default_nettype wire

>>> rtl/olar_chk.sv
`default_nettype none
module olar_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  i_req_type,
    input wire logic        o_strobe,
    input wire logic [1:0]  o_status,
    input wire logic [31:0] o_entry_value,
    input wire logic        o_last
);
    import olar_pkg::*;

    a_append_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_type == REQ_APPEND |=> o_strobe && o_last && !busy)
        else $error("append did not give one final word");

    a_unused_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_type != REQ_APPEND && i_req_type != REQ_REMOVE
        && i_req_type != REQ_READ |=> !o_strobe && !busy)
        else $error("unused request produced activity");

    a_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status != ST_DONE |-> o_last && o_entry_value == '0)
        else $error("status word malformed");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("non-final word while idle");

endmodule

bind ordered_list_append_remove olar_chk u_olar_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_req_type    (i_req_type),
    .o_strobe      (o_strobe),
    .o_status      (o_status),
    .o_entry_value (o_entry_value),
    .o_last        (o_last)
);
`default_nettype wire
